[rtl/core/optb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optb_pkg: shared types and constants for the timer bank
// Command codes, slot command struct and defaults.
// ----------------------------------------------------------------------------
package optb_pkg;

  localparam int unsigned NumTimersDef = 8;
  localparam logic [16:0] HzReset      = 17'd1000;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START_T = 3'd1,
    CMD_START_M = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SERVICE = 3'd4
  } cmd_e;

  // per-cycle operation applied by every cell
  typedef enum logic [5:0] {
    OP_NONE  = 6'b000001,
    OP_TICK  = 6'b000010,
    OP_START = 6'b000100,
    OP_STOP  = 6'b001000,
    OP_SERVE = 6'b010000,
    OP_FIND  = 6'b100000
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic [31:0] ticks;
    logic        per;
    logic        tgt_active;  // target slot already active
    logic        tgt_periodic;
  } bcast_t;

endpackage

[rtl/core/optb_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optb_cell: one timer slot
// Holds expiry, period, mode, flags and rank. The find chain passes the best
// pending candidate (lowest rank) from neighbor to neighbor.
// ----------------------------------------------------------------------------
module optb_cell
  import optb_pkg::*;
#(
  parameter int unsigned RW = 3,
  parameter int unsigned IW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bcast_t        bc_i,
  input  logic          sel_i,      // this cell is the command target
  input  logic [RW-1:0] tgt_rank_i, // rank of the retiring slot
  input  logic          c_found_i,
  input  logic [RW-1:0] c_rank_i,
  input  logic [IW-1:0] c_idx_i,
  input  logic [IW-1:0] my_idx_i,
  output logic          c_found_o,
  output logic [RW-1:0] c_rank_o,
  output logic [IW-1:0] c_idx_o,
  output logic          active_o,
  output logic          pending_o,
  output logic          periodic_o,
  output logic [RW-1:0] rank_o,
  output logic          fired_o
);

  logic [31:0]   exp_q, exp_d, rel_q, rel_d;
  logic          per_q, per_d, act_q, act_d, pen_q, pen_d;
  logic [RW-1:0] rank_q, rank_d;
  logic          cand;

  assign cand      = act_q && pen_q && (!c_found_i || rank_q < c_rank_i);
  assign c_found_o = c_found_i || cand;
  assign c_rank_o  = cand ? rank_q : c_rank_i;
  assign c_idx_o   = cand ? my_idx_i : c_idx_i;
  logic [31:0] diff;
  assign diff    = bc_i.now - exp_q;
  assign fired_o = (bc_i.op == OP_TICK) && act_q && !pen_q && !diff[31];

  always_comb begin
    exp_d  = exp_q;
    rel_d  = rel_q;
    per_d  = per_q;
    act_d  = act_q;
    pen_d  = pen_q;
    rank_d = rank_q;
    case (bc_i.op)
      OP_TICK: begin
        if (fired_o) pen_d = 1'b1;
      end
      OP_START: begin
        if (sel_i) begin
          per_d = bc_i.per;
          rel_d = bc_i.ticks;
          exp_d = bc_i.now + bc_i.ticks;
          pen_d = 1'b0;
          if (!act_q) begin
            act_d  = 1'b1;
            rank_d = '0;
          end
        end else if (act_q && !bc_i.tgt_active) begin
          rank_d = rank_q + 1'b1;
        end
      end
      OP_STOP, OP_SERVE: begin
        if (sel_i && bc_i.op == OP_SERVE && bc_i.tgt_periodic) begin
          pen_d = 1'b0;
          exp_d = exp_q + rel_q;
        end else if (sel_i) begin
          act_d  = 1'b0;
          pen_d  = 1'b0;
          rank_d = '0;
        end else if (act_q && rank_q > tgt_rank_i &&
                     !(bc_i.op == OP_SERVE && bc_i.tgt_periodic)) begin
          rank_d = rank_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      pen_q  <= 1'b0;
      per_q  <= 1'b0;
      rank_q <= '0;
      exp_q  <= '0;
      rel_q  <= '0;
    end else begin
      act_q  <= act_d;
      pen_q  <= pen_d;
      per_q  <= per_d;
      rank_q <= rank_d;
      exp_q  <= exp_d;
      rel_q  <= rel_d;
    end
  end

  assign active_o   = act_q;
  assign pending_o  = pen_q;
  assign periodic_o = per_q;
  assign rank_o     = rank_q;

endmodule

[rtl/core/oneshot_periodic_timer_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank: multi-slot one-shot / periodic timer
// Row of slot cells under a small sequencer; ms conversion by multiply/divide.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i in_stall_o cmd/slot/periodic/period | request in
//  out     | out_valid_o out_stall_i wake..pending_mask | result out
//  cfg     | cfg_we_i cfg_wdata_i                      | register write
// Each request passes decode, apply and result; a ms start adds the multiply,
// the divide-by-1000 reciprocal step and a fix step. The service search
// runs through the cell chain. Reset clears all slots and sets hz to 1000.
// A stalled result holds; a new request is taken once the result is gone.
module oneshot_periodic_timer_bank
  import optb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  slot_i,
  input  logic        periodic_i,
  input  logic [31:0] period_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        wake_o,
  output logic        served_valid_o,
  output logic [2:0]  served_slot_o,
  output logic        rejected_o,
  output logic [7:0]  active_mask_o,
  output logic [7:0]  pending_mask_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  localparam int unsigned RW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned IW = RW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_FIX  = 6'b001000,
    S_APPLY= 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e      st_q, st_d;
  logic [16:0] hz_q;
  logic [31:0] now_q;
  logic [2:0]  cmd_q, slot_q;
  logic        per_q;
  logic [31:0] per32_q, t_q;
  logic [63:0] prod_q;
  logic        wake_q, sv_q, rej_q;
  logic [2:0]  ss_q;

  logic [NUM_TIMERS-1:0] act, pen, perm, fired, sel;
  logic [RW-1:0]         rank [NUM_TIMERS];
  logic                  cf [NUM_TIMERS+1];
  logic [RW-1:0]         cr [NUM_TIMERS+1];
  logic [IW-1:0]         ci [NUM_TIMERS+1];
  bcast_t                bc;
  logic                  slot_ok;
  logic [IW-1:0]         tgt;
  logic [RW-1:0]         tgt_rank;

  assign slot_ok = {29'd0, slot_q} < 32'(NUM_TIMERS);
  assign cf[0] = 1'b0;
  assign cr[0] = '0;
  assign ci[0] = '0;
  assign tgt   = (cmd_q == CMD_SERVICE) ? ci[NUM_TIMERS] : IW'(slot_q);
  assign tgt_rank = rank[tgt];

  always_comb begin
    bc.now          = now_q;
    bc.ticks        = t_q;
    bc.per          = per_q;
    bc.tgt_active   = act[tgt];
    bc.tgt_periodic = perm[tgt];
    bc.op           = OP_NONE;
    sel             = '0;
    if (st_q == S_APPLY) begin
      case (cmd_q)
        CMD_TICK: bc.op = OP_TICK;
        CMD_START_T, CMD_START_M: begin
          if (slot_ok && t_q != 32'd0) begin
            bc.op = OP_START;
            sel[tgt] = 1'b1;
          end
        end
        CMD_STOP: begin
          if (slot_ok && act[tgt]) begin
            bc.op = OP_STOP;
            sel[tgt] = 1'b1;
          end
        end
        CMD_SERVICE: begin
          if (cf[NUM_TIMERS]) begin
            bc.op = OP_SERVE;
            sel[tgt] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    optb_cell #(.RW(RW), .IW(IW)) u_cell (
      .clk_i, .rst_ni, .bc_i(bc), .sel_i(sel[g]), .tgt_rank_i(tgt_rank),
      .c_found_i(cf[g]), .c_rank_i(cr[g]), .c_idx_i(ci[g]), .my_idx_i(IW'(g)),
      .c_found_o(cf[g+1]), .c_rank_o(cr[g+1]), .c_idx_o(ci[g+1]),
      .active_o(act[g]), .pending_o(pen[g]), .periodic_o(perm[g]),
      .rank_o(rank[g]), .fired_o(fired[g])
    );
  end

  // reciprocal of 1000: floor(x/1000) = (x * 274877907) >> 38 for x < 2^32
  localparam logic [31:0] Recip = 32'd274877907;
  logic [31:0] sum;
  assign sum = prod_q[31:0] + 32'd999;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (in_valid_i) st_d = (cmd_i == CMD_START_M) ? S_MUL : S_APPLY;
      S_MUL:   st_d = S_DIV;
      S_DIV:   st_d = S_FIX;
      S_FIX:   st_d = S_APPLY;
      S_APPLY: st_d = S_OUT;
      S_OUT:   if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (st_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      hz_q  <= HzReset;
      now_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) hz_q <= cfg_wdata_i;
      if (st_q == S_IDLE && in_valid_i && cmd_i == CMD_TICK) now_q <= now_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cmd_q   <= cmd_i;
        slot_q  <= slot_i;
        per_q   <= periodic_i;
        per32_q <= period_i;
        t_q     <= period_i;
      end
      S_MUL: prod_q <= {32'd0, per32_q[31:0] * {15'd0, hz_q}};
      S_DIV: prod_q <= sum * Recip;
      S_FIX: t_q    <= (prod_q[63:38] == 26'd0) ? 32'd1 : {6'd0, prod_q[63:38]};
      S_APPLY: begin
        wake_q <= (cmd_q == CMD_TICK) && (|fired);
        sv_q   <= (cmd_q == CMD_SERVICE) && cf[NUM_TIMERS];
        ss_q   <= (cmd_q == CMD_SERVICE && cf[NUM_TIMERS]) ? 3'(ci[NUM_TIMERS]) : 3'd0;
        rej_q  <= (cmd_q == CMD_START_T) && (t_q == 32'd0);
      end
      default: ;
    endcase
  end

  logic [7:0] am, pm;
  always_comb begin
    am = '0;
    pm = '0;
    for (int i = 0; i < NUM_TIMERS && i < 8; i++) begin
      am[i] = act[i];
      pm[i] = pen[i];
    end
  end

  assign out_valid_o    = (st_q == S_OUT);
  assign wake_o         = wake_q;
  assign served_valid_o = sv_q;
  assign served_slot_o  = ss_q;
  assign rejected_o     = rej_q;
  assign active_mask_o  = am;
  assign pending_mask_o = pm;

endmodule
